/* src/assert_macros.svh */
// Concurrent checks clocked on clk, held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/gvct_pkg.sv */
`default_nettype none
package gvct_pkg;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_QUERY = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_RSQ = 2'd1;

  localparam int COUNT_W = 16;
  localparam int VSUM_W  = 40;
  localparam int SSUM_W  = 56;
  localparam int PSUM_W  = 44;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int MUL_A_W = 128;
  localparam int MUL_B_W = 64;
  localparam int FRAC_W  = 32;
  localparam int ROOT_W  = 16;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VSUM_W-1:0]  vsum;
    logic [SSUM_W-1:0]  ssum;
    logic [PSUM_W-1:0]  psum;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

endpackage
`default_nettype wire

/* src/gvct_ram.sv */
`default_nettype none
module gvct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/gvct_mul.sv */
`default_nettype none
module gvct_mul import gvct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output seq_sts_t                sts,
  output logic      [MUL_A_W-1:0] product
);

  logic [MUL_A_W-1:0] mcand;
  logic [MUL_B_W-1:0] mplier;
  logic [MUL_A_W-1:0] acc;
  logic               busy;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= a;
        mplier <= b;
        acc    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[MUL_A_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MUL_B_W-1:1]};
        end
      end
    end
  end

  assign sts     = '{busy: busy, done: done};
  assign product = acc;

endmodule
`default_nettype wire

/* src/gvct_div.sv */
`default_nettype none
module gvct_div import gvct_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] num,
  input  wire logic [MUL_A_W-1:0] den,
  output seq_sts_t                sts,
  output logic                    sat,
  output logic      [FRAC_W-1:0]  quo
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [MUL_A_W-1:0] rem;
  logic [MUL_A_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [MUL_A_W-1:0] shifted;

  assign shifted = {rem[MUL_A_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num;
        dvs <= den;
        quo <= '0;
        cnt <= CNT_W'(FRAC_W);
        if (num >= den) begin
          sat  <= 1'b1;
          done <= 1'b1;
        end else begin
          sat  <= 1'b0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (shifted >= dvs) begin
          rem <= shifted - dvs;
          quo <= {quo[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts = '{busy: busy, done: done};

endmodule
`default_nettype wire

/* src/gvct_sqrt.sv */
`default_nettype none
module gvct_sqrt import gvct_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [FRAC_W-1:0] radicand,
  output seq_sts_t               sts,
  output logic      [ROOT_W-1:0] root
);

  logic [FRAC_W-1:0] rad;
  logic [ROOT_W-1:0] bitv;
  logic              busy;
  logic              done;
  logic [ROOT_W-1:0] trial;
  logic [FRAC_W-1:0] trial_sq;

  assign trial    = root | bitv;
  assign trial_sq = FRAC_W'(trial) * FRAC_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        root <= '0;
        bitv <= {1'b1, {(ROOT_W-1){1'b0}}};
        busy <= 1'b1;
      end else if (busy) begin
        if (trial_sq <= rad) begin
          root <= trial;
        end
        bitv <= {1'b0, bitv[ROOT_W-1:1]};
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts = '{busy: busy, done: done};

endmodule
`default_nettype wire

/* src/group_value_correlation_table_top.sv */
// Add request: cell read, then write back; clear request: a sweep that zeroes all 2^AW cells.
// Query request: unless mode 0 or out of range, a scan of groups 1 to highest, up to eight bit-serial
// multiplies (fewer if a variance is not positive), a divide, and a square root unless mode 1 or saturated.
// One request at a time; the result register lets the next request in while a result waits.
// Reset: stat_mode 0, no result, then a sweep over all 2^AW cells (8192 by default) zeroes
// the cell memory with req_stall high; configuration writes are taken throughout.
`default_nettype none
`include "assert_macros.svh"
module group_value_correlation_table_top import gvct_pkg::*; #(
  parameter int GROUP_COUNT   = 8,
  parameter int CHANNEL_COUNT = 16,
  parameter int POINT_COUNT   = 64,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic        [1:0]             func,
  input  wire logic        [2:0]             group_number,
  input  wire logic        [3:0]             channel,
  input  wire logic        [5:0]             time_index,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic signed      [15:0]            correlation,
  output logic                               valid_res,
  output logic             [2:0]             groups_used,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic        [1:0]             stat_mode
);

  localparam int GW    = $clog2(GROUP_COUNT);
  localparam int CW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PW    = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int AW    = GW + CW + PW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = COUNT_W + GW;
  localparam int SXW   = COUNT_W + 2 * GW;
  localparam int SXXW  = COUNT_W + 3 * GW;
  localparam int SQW   = 2 * SAMPLE_BITS;
  localparam int PRW   = SAMPLE_BITS + 4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD, S_SCAN, S_DRAIN, S_MUL_GO, S_MUL_WAIT,
    S_DIV_WAIT, S_SQRT_WAIT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NSXX, OP_SXSX, OP_NSYY, OP_AYAY, OP_NSXY, OP_SXSY, OP_MAG2, OP_DEN
  } mop_t;

  state_t state;
  mop_t   op;

  logic [1:0]                mode;
  logic [2:0]                highest;
  logic [AW-1:0]             clr_cnt;
  logic [AW-1:0]             add_addr;
  logic signed [SAMPLE_BITS-1:0] add_s;
  logic [SQW-1:0]            add_sq;
  logic signed [PRW-1:0]     add_pr;
  logic [CW-1:0]             q_ch;
  logic [PW-1:0]             q_tm;
  logic [GW-1:0]             g;
  logic [GW-1:0]             gq;
  logic [2*GW-1:0]           gsq;
  logic                      pend;
  logic [NW-1:0]             n;
  logic [SXW-1:0]            sx;
  logic [SXXW-1:0]           sxx;
  logic [63:0]               sy;
  logic [63:0]               syy;
  logic [63:0]               sxy;
  logic [63:0]               t;
  logic [63:0]               cx;
  logic [MUL_A_W-1:0]        wp;
  logic [MUL_A_W-1:0]        cy;
  logic [63:0]               mag;
  logic                      neg;
  logic [15:0]               res;
  logic                      vres;
  logic                      div_start;
  logic                      sqrt_start;

  logic                      req_take;
  logic                      in_range;
  logic [AW-1:0]             in_addr;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [CELL_W-1:0]         ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [CELL_W-1:0]         ram_rdata;
  cell_t                     rd_cell;
  cell_t                     upd_cell;
  logic [GW+COUNT_W-1:0]     gc;
  logic [2*GW+COUNT_W-1:0]   ggc;
  logic [63:0]               ay;
  logic [63:0]               cxy_d;
  logic                      mul_start;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_A_W-1:0]        prod;
  seq_sts_t                  mul_sts;
  seq_sts_t                  div_sts;
  seq_sts_t                  sqrt_sts;
  logic                      div_sat;
  logic [FRAC_W-1:0]         div_q;
  logic [ROOT_W-1:0]         root;
  logic [16:0]               rsq_t;
  logic [16:0]               rt_m;
  logic [16:0]               rt_neg;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  assign in_range = (int'(group_number) < GROUP_COUNT) &&
                    (int'(channel) < CHANNEL_COUNT) &&
                    (int'(time_index) < POINT_COUNT);
  assign in_addr  = {GW'(group_number), CW'(channel), PW'(time_index)};

  assign rd_cell = cell_t'(ram_rdata);
  assign gc      = gq * rd_cell.count;
  assign ggc     = gsq * rd_cell.count;
  assign ay      = sy[63] ? (64'd0 - sy) : sy;
  assign cxy_d   = t - prod[63:0];

  always_comb begin
    upd_cell       = rd_cell;
    upd_cell.count = rd_cell.count + 1'b1;
    upd_cell.vsum  = rd_cell.vsum + VSUM_W'(add_s);
    if (mode != MODE_OFF) begin
      upd_cell.ssum = rd_cell.ssum + SSUM_W'(add_sq);
      upd_cell.psum = rd_cell.psum + PSUM_W'(add_pr);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = add_addr;
    ram_wdata = CELL_W'(upd_cell);
    ram_raddr = in_addr;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_ADD: begin
        ram_we = (rd_cell.count != COUNT_MAX);
      end
      S_SCAN: begin
        ram_raddr = {g, q_ch, q_tm};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mul_start = (state == S_MUL_GO);
    mul_a     = '0;
    mul_b     = '0;
    unique case (op)
      OP_NSXX: begin
        mul_a = MUL_A_W'(sxx);
        mul_b = MUL_B_W'(n);
      end
      OP_SXSX: begin
        mul_a = MUL_A_W'(sx);
        mul_b = MUL_B_W'(sx);
      end
      OP_NSYY: begin
        mul_a = MUL_A_W'(syy);
        mul_b = MUL_B_W'(n);
      end
      OP_AYAY: begin
        mul_a = MUL_A_W'(ay);
        mul_b = ay;
      end
      OP_NSXY: begin
        mul_a = MUL_A_W'(sxy);
        mul_b = MUL_B_W'(n);
      end
      OP_SXSY: begin
        mul_a = MUL_A_W'(sy);
        mul_b = MUL_B_W'(sx);
      end
      OP_MAG2: begin
        mul_a = MUL_A_W'(mag);
        mul_b = mag;
      end
      OP_DEN: begin
        mul_a = cy;
        mul_b = cx;
      end
      default: begin
      end
    endcase
  end

  assign rsq_t  = ({1'b0, div_q[31:16]} + 17'd1) >> 1;
  assign rt_m   = ({1'b0, root} + 17'd1) >> 1;
  assign rt_neg = 17'd0 - rt_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      op         <= OP_NSXX;
      mode       <= MODE_OFF;
      highest    <= '0;
      clr_cnt    <= '0;
      pend       <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mode <= stat_mode;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if ((state == S_SCAN || state == S_DRAIN) && pend) begin
        n   <= n + NW'(rd_cell.count);
        sx  <= sx + SXW'(gc);
        sxx <= sxx + SXXW'(ggc);
        sy  <= sy + 64'($signed(rd_cell.vsum));
        syy <= syy + 64'(rd_cell.ssum);
        sxy <= sxy + 64'($signed(rd_cell.psum));
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            case (func)
              FN_ADD: begin
                if (in_range) begin
                  if (group_number > highest) begin
                    highest <= group_number;
                  end
                  add_addr <= in_addr;
                  add_s    <= sample;
                  add_sq   <= SQW'(sample * sample);
                  add_pr   <= PRW'(sample) * $signed({1'b0, group_number});
                  state    <= S_ADD;
                end
              end
              FN_QUERY: begin
                q_ch <= CW'(channel);
                q_tm <= PW'(time_index);
                res  <= '0;
                vres <= 1'b0;
                n    <= '0;
                sx   <= '0;
                sxx  <= '0;
                sy   <= '0;
                syy  <= '0;
                sxy  <= '0;
                g    <= GW'(1);
                pend <= 1'b0;
                if (mode == MODE_OFF || int'(channel) >= CHANNEL_COUNT ||
                    int'(time_index) >= POINT_COUNT || highest == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              FN_CLEAR: begin
                clr_cnt <= '0;
                highest <= '0;
                state   <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          pend <= 1'b1;
          gq   <= g;
          gsq  <= g * g;
          if (g == GW'(highest)) begin
            state <= S_DRAIN;
          end else begin
            g <= g + 1'b1;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          op    <= OP_NSXX;
          state <= S_MUL_GO;
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_sts.done) begin
            op    <= mop_t'(op + 1'b1);
            state <= S_MUL_GO;
            unique case (op)
              OP_NSXX, OP_NSXY: begin
                t <= prod[63:0];
              end
              OP_SXSX: begin
                if (t <= prod[63:0]) begin
                  state <= S_DONE;
                end
                cx <= t - prod[63:0];
              end
              OP_NSYY, OP_MAG2: begin
                wp <= prod;
              end
              OP_AYAY: begin
                if (wp <= prod) begin
                  state <= S_DONE;
                end
                cy <= wp - prod;
              end
              OP_SXSY: begin
                neg <= cxy_d[63];
                mag <= cxy_d[63] ? (64'd0 - cxy_d) : cxy_d;
              end
              OP_DEN: begin
                div_start <= 1'b1;
                state     <= S_DIV_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV_WAIT: begin
          if (div_sts.done) begin
            if (mode == MODE_RSQ) begin
              vres  <= 1'b1;
              res   <= (div_sat || rsq_t > 17'd32767) ? 16'h7FFF : rsq_t[15:0];
              state <= S_DONE;
            end else if (div_sat) begin
              vres  <= 1'b1;
              res   <= neg ? 16'h8000 : 16'h7FFF;
              state <= S_DONE;
            end else begin
              sqrt_start <= 1'b1;
              state      <= S_SQRT_WAIT;
            end
          end
        end
        S_SQRT_WAIT: begin
          if (sqrt_sts.done) begin
            vres <= 1'b1;
            if (neg) begin
              res <= rt_neg[15:0];
            end else begin
              res <= (rt_m > 17'd32767) ? 16'h7FFF : rt_m[15:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            correlation <= res;
            valid_res   <= vres;
            groups_used <= highest;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gvct_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gvct_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .sts    (mul_sts),
    .product(prod)
  );

  gvct_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (wp),
    .den  (prod),
    .sts  (div_sts),
    .sat  (div_sat),
    .quo  (div_q)
  );

  gvct_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(div_q),
    .sts     (sqrt_sts),
    .root    (root)
  );

  `ASSERT_IMPLIES(a_invalid_zero, rsp_valid && !valid_res, correlation == 16'sd0, "invalid result not zero")
  `ASSERT_NEXT(a_clear_highest, req_take && func == FN_CLEAR, highest == 3'd0, "clear kept group")
  `ASSERT_ALWAYS(a_units_excl, !(mul_sts.busy && div_sts.busy), "multiply and divide overlap")
  `ASSERT_IMPLIES(a_sqrt_state, sqrt_sts.busy, state == S_SQRT_WAIT, "root unit busy out of turn")

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import gvct_pkg::*;

  localparam logic [1:0] FN_NONE    = 2'd3;
  localparam logic [1:0] MODE_R     = 2'd2;
  localparam logic [1:0] MODE_R_ALT = 2'd3;
  localparam int CELLS       = 8192;
  localparam int SETTLE      = 9000;
  localparam int WATCHDOG    = 30000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  fn;
    logic [2:0]  grp;
    logic [3:0]  ch;
    logic [5:0]  tm;
    logic [15:0] smp;
  } req_t;

  typedef struct {
    logic [15:0] corr;
    logic        vres;
    logic [2:0]  gu;
  } corr_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  func;
  logic [2:0]  group_number;
  logic [3:0]  channel;
  logic [5:0]  time_index;
  logic [15:0] sample;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [15:0] correlation;
  logic        valid_res;
  logic [2:0]  groups_used;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  stat_mode;

  logic [15:0] cnt_tab [CELLS];
  logic [39:0] vsum_tab[CELLS];
  logic [55:0] ssum_tab[CELLS];
  logic [43:0] psum_tab[CELLS];
  logic [2:0]  top_group;
  logic [1:0]  mode_now;

  corr_t pending_corr[$];
  int    errors;
  int    checked;
  int    valid_seen;
  int    sent;
  int    send_pct;
  int    recv_pct;
  int    hold_cycles;
  int    idle_cnt;
  logic [3:0] pool_ch[2];
  logic [5:0] pool_tm[2];
  int    slope;
  int    noise;

  group_value_correlation_table_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .func(func), .group_number(group_number), .channel(channel),
    .time_index(time_index), .sample(sample),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .correlation(correlation), .valid_res(valid_res), .groups_used(groups_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .stat_mode(stat_mode)
  );

  always #6 clk = ~clk;

  function automatic void clear_table();
    for (int i = 0; i < CELLS; i++) begin
      cnt_tab[i] = '0;
      vsum_tab[i] = '0;
      ssum_tab[i] = '0;
      psum_tab[i] = '0;
    end
    top_group = '0;
  endfunction

  function automatic void accumulate(req_t it);
    logic [12:0] idx;
    logic [63:0] s;
    logic [63:0] sq;
    logic [63:0] pr;
    idx = {it.grp, it.ch, it.tm};
    s = {{48{it.smp[15]}}, it.smp};
    if (it.grp > top_group) top_group = it.grp;
    if (cnt_tab[idx] == COUNT_MAX) return;
    cnt_tab[idx] = cnt_tab[idx] + 1'b1;
    vsum_tab[idx] = vsum_tab[idx] + s[39:0];
    if (mode_now != MODE_OFF) begin
      sq = s * s;
      pr = s * {61'b0, it.grp};
      ssum_tab[idx] = ssum_tab[idx] + sq[55:0];
      psum_tab[idx] = psum_tab[idx] + pr[43:0];
    end
  endfunction

  function automatic corr_t predict_corr(logic [3:0] ch, logic [5:0] tm);
    corr_t r;
    logic [12:0] idx;
    logic [63:0] n, sx, sxx, sy, syy, sxy, c, gx, cx, ay, cxy, mag, f, rt, t, m, res;
    logic [127:0] p, q, cy, num, den;
    logic neg, sat;
    n = 0; sx = 0; sxx = 0; sy = 0; syy = 0; sxy = 0; f = 0; sat = 1'b0;
    r.corr = '0;
    r.vres = 1'b0;
    r.gu = top_group;
    if (mode_now == MODE_OFF) return r;
    for (int g = 1; g <= top_group; g++) begin
      idx = {g[2:0], ch, tm};
      gx = 64'(g);
      c = {48'b0, cnt_tab[idx]};
      n = n + c;
      sx = sx + gx * c;
      sxx = sxx + gx * gx * c;
      sy = sy + {{24{vsum_tab[idx][39]}}, vsum_tab[idx]};
      syy = syy + {8'b0, ssum_tab[idx]};
      sxy = sxy + {{20{psum_tab[idx][43]}}, psum_tab[idx]};
    end
    if (n * sxx <= sx * sx) return r;
    cx = n * sxx - sx * sx;
    ay = sy[63] ? -sy : sy;
    p = {64'b0, n} * {64'b0, syy};
    q = {64'b0, ay} * {64'b0, ay};
    if (p <= q) return r;
    cy = p - q;
    cxy = n * sxy - sx * sy;
    neg = cxy[63];
    mag = neg ? -cxy : cxy;
    num = {64'b0, mag} * {64'b0, mag};
    den = cy * {64'b0, cx};
    if (num >= den) sat = 1'b1;
    else begin
      for (int k = 0; k < 32; k++) begin
        num = num << 1;
        f = f << 1;
        if (num >= den) begin
          num = num - den;
          f[0] = 1'b1;
        end
      end
    end
    if (mode_now == MODE_RSQ) begin
      res = sat ? 64'd32767 : (((f >> 16) + 1) >> 1);
      if (res > 64'd32767) res = 64'd32767;
    end else begin
      rt = 0;
      for (int b = 15; b >= 0; b--) begin
        t = rt | (64'd1 << b);
        if (t * t <= f) rt = t;
      end
      m = sat ? 64'd32768 : ((rt + 1) >> 1);
      if (neg) res = -m;
      else res = (m > 64'd32767) ? 64'd32767 : m;
    end
    r.corr = res[15:0];
    r.vres = 1'b1;
    return r;
  endfunction

  task automatic send_req(req_t it);
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      req_valid = 1'b0;
    end
    @(negedge clk);
    req_valid = 1'b1;
    func = it.fn;
    group_number = it.grp;
    channel = it.ch;
    time_index = it.tm;
    sample = it.smp;
    do @(posedge clk); while (req_stall);
    sent++;
    case (it.fn)
      FN_ADD:   accumulate(it);
      FN_QUERY: pending_corr.push_back(predict_corr(it.ch, it.tm));
      FN_CLEAR: clear_table();
      default: ;
    endcase
  endtask

  task automatic drop_valid();
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    while (pending_corr.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    stat_mode = v;
    do @(posedge clk); while (!cfg_ready);
    mode_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_fields(logic [1:0] fn, logic [2:0] grp, logic [3:0] ch,
                             logic [5:0] tm, logic [15:0] smp);
    req_t it;
    it.fn = fn; it.grp = grp; it.ch = ch; it.tm = tm; it.smp = smp;
    send_req(it);
  endtask

  function automatic req_t rand_req();
    req_t it;
    int sel;
    int v;
    sel = $urandom_range(999);
    it.grp = 3'($urandom_range(7));
    if ($urandom_range(9) != 0) begin
      it.ch = pool_ch[$urandom_range(1)];
      it.tm = pool_tm[$urandom_range(1)];
    end else begin
      it.ch = 4'($urandom_range(15));
      it.tm = 6'($urandom_range(63));
    end
    if (sel < 60) it.fn = FN_QUERY;
    else if (sel < 62) it.fn = FN_CLEAR;
    else if (sel < 80) it.fn = FN_NONE;
    else it.fn = FN_ADD;
    if ($urandom_range(9) == 0) it.smp = 16'($urandom);
    else begin
      v = slope * int'(it.grp) + $urandom_range(2 * noise) - noise;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      it.smp = v[15:0];
    end
    return it;
  endfunction

  task automatic test_stats_off();
    send_fields(FN_ADD, 3'd1, 4'd1, 6'd1, 16'd100);
    send_fields(FN_ADD, 3'd2, 4'd1, 6'd1, 16'd300);
    send_fields(FN_QUERY, 3'd0, 4'd1, 6'd1, 16'd0);
  endtask

  task automatic test_directed();
    set_mode(MODE_R);
    for (int g = 1; g < 8; g++) send_fields(FN_ADD, g[2:0], 4'd2, 6'd2, 16'(1000 * g));
    send_fields(FN_QUERY, 3'd0, 4'd2, 6'd2, 16'd0);
    for (int g = 1; g < 8; g++) send_fields(FN_ADD, g[2:0], 4'd3, 6'd3, 16'(-4000 * g));
    send_fields(FN_QUERY, 3'd0, 4'd3, 6'd3, 16'd0);
    send_fields(FN_ADD, 3'd7, 4'd15, 6'd63, 16'h7fff);
    send_fields(FN_ADD, 3'd1, 4'd15, 6'd63, 16'h8000);
    send_fields(FN_ADD, 3'd0, 4'd15, 6'd63, 16'h7fff);
    send_fields(FN_ADD, 3'd4, 4'd15, 6'd63, 16'h1234);
    send_fields(FN_QUERY, 3'd0, 4'd15, 6'd63, 16'd0);
    send_fields(FN_QUERY, 3'd0, 4'd0, 6'd0, 16'd0);
    send_fields(FN_ADD, 3'd5, 4'd4, 6'd4, 16'd9);
    send_fields(FN_ADD, 3'd5, 4'd4, 6'd4, 16'd90);
    send_fields(FN_QUERY, 3'd0, 4'd4, 6'd4, 16'd0);
    send_fields(FN_ADD, 3'd1, 4'd5, 6'd5, 16'd7);
    send_fields(FN_ADD, 3'd2, 4'd5, 6'd5, 16'd7);
    send_fields(FN_QUERY, 3'd0, 4'd5, 6'd5, 16'd0);
    send_fields(FN_QUERY, 3'd0, 4'd1, 6'd1, 16'd0);
    send_fields(FN_NONE, 3'd7, 4'd15, 6'd63, 16'hffff);
    set_mode(MODE_RSQ);
    send_fields(FN_QUERY, 3'd0, 4'd2, 6'd2, 16'd0);
    send_fields(FN_QUERY, 3'd0, 4'd15, 6'd63, 16'd0);
    send_fields(FN_CLEAR, 3'd0, 4'd0, 6'd0, 16'd0);
    send_fields(FN_QUERY, 3'd0, 4'd2, 6'd2, 16'd0);
  endtask

  task automatic test_random(int spct, int rpct, logic [1:0] mode, int count);
    set_mode(mode);
    send_pct = spct;
    recv_pct = rpct;
    pool_ch[0] = 4'($urandom_range(15));
    pool_ch[1] = 4'($urandom_range(15));
    pool_tm[0] = 6'($urandom_range(63));
    pool_tm[1] = 6'($urandom_range(63));
    slope = $urandom_range(8000) - 4000;
    noise = $urandom_range(3000);
    for (int i = 0; i < count; i++) send_req(rand_req());
  endtask

  task automatic test_backpressure();
    send_pct = 0;
    recv_pct = 0;
    drop_valid();
    hold_cycles = 5000;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_fields(FN_QUERY, 3'd0, pool_ch[0], pool_tm[0], 16'd0);
      else send_fields(FN_ADD, 3'($urandom_range(7)), pool_ch[0], pool_tm[0],
                       16'($urandom));
    end
    drain();
    for (int i = 0; i < 20; i++) send_req(rand_req());
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    corr_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_corr.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: corr %0d valid %0d groups %0d",
                   $signed(correlation), valid_res, groups_used);
      end else begin
        e = pending_corr.pop_front();
        checked++;
        if (e.vres) valid_seen++;
        if (correlation !== e.corr || valid_res !== e.vres || groups_used !== e.gu) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: corr exp %0d got %0d, valid exp %0d got %0d, groups exp %0d got %0d",
                     $signed(e.corr), $signed(correlation), e.vres, valid_res,
                     e.gu, groups_used);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    func = FN_ADD;
    group_number = '0;
    channel = '0;
    time_index = '0;
    sample = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    stat_mode = MODE_OFF;
    errors = 0;
    checked = 0;
    valid_seen = 0;
    sent = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_cycles = 0;
    idle_cnt = 0;
    mode_now = MODE_OFF;
    clear_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_stats_off();
    test_directed();
    test_random(10, 70, MODE_R, 380);
    test_random(70, 10, MODE_RSQ, 380);
    test_random(0, 0, MODE_OFF, 60);
    test_random(0, 0, MODE_R_ALT, 330);
    test_backpressure();

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests in all modes and idle patterns, clears, long backpressure.",
             sent);
    $display("Checked %0d correlation results, %0d of them valid; %0d errors.",
             checked, valid_seen, errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
